// ----- hw/rtl/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, widths and constants of the sieve divisor enumerator.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int unsigned VALUE_W            = 12;
   localparam int unsigned FACTOR_W           = 6;
   localparam int unsigned TABLE_AW           = VALUE_W - 1;
   localparam int unsigned TABLE_DEPTH        = 1 << TABLE_AW;
   localparam int unsigned SPF_MAX_VALUE      = 4095;
   localparam int unsigned SPF_DIVISOR_SLOTS  = 48;

   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [FACTOR_W-1:0] factor_type;

   // class of a transaction as seen by the front end
   typedef enum logic [1:0] {
      KIND_TRIVIAL,
      KIND_EVEN,
      KIND_ODD
   } spf_kind_type;

   typedef struct packed {
      value_type    value;
      spf_kind_type kind;
   } spf_item_type;

   typedef struct packed {
      logic                en;
      logic [TABLE_AW-1:0] addr;
   } spf_lookup_type;

   // odd primes below 64, the only sieve strides a 12-bit range needs
   function automatic logic spf_is_odd_prime(input factor_type p);
      logic res;
      res = 1'b0;
      case (p)
         6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29,
         6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53, 6'd59, 6'd61: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ----- hw/rtl/spf_ifs.sv -----
// ----------------------------------------------------------------------------
// spf channel interfaces
// Valid/ready channels for request values and divisor responses.
// ----------------------------------------------------------------------------
interface spf_req_if;
   import spf_pkg::*;
   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface spf_rsp_if;
   import spf_pkg::*;
   logic      valid;
   logic      ready;
   value_type divisor;
   logic      last;

   modport source (output valid, output divisor, output last, input ready);
   modport sink   (input valid, input divisor, input last, output ready);
endinterface

// ----- hw/rtl/spf_sieve_divisor_enumerator.sv -----
// ----------------------------------------------------------------------------
// spf_sieve_divisor_enumerator
// Lists all divisors of a 12-bit value using a smallest-prime-factor sieve.
// ----------------------------------------------------------------------------
// After reset the block builds its factor table, a clearing pass followed by
// sieve marking, during which req_ch.ready stays low. Each accepted value
// then produces one response transaction per divisor, 1 first, then for
// every prime in turn all divisors so far times p, p^2 and so on; the final
// divisor carries last=1. Values 0 and 1 give the single divisor 1. At most
// DIVISOR_SLOTS divisors are kept; the run is cut there and the last kept
// one is flagged. Steps per value: a dequeue, a prime-selection step ahead
// of every prime after the first and once more before draining, a table
// read for each odd prime, and a trial division in the shared bit-serial
// divider for every prime power found, plus one that ends a prime unless
// the cofactor has reached 1. Each prime power found then appends its new
// divisors to the list, and emission reads them back from it in order. The
// divider dominates the time a value takes; 3360 is a value with a full run
// of 48 divisors. A two-entry queue in front holds waiting values, and a
// two-entry output buffer lets emission run at one divisor per cycle while
// the sink does not stall; the engine holds in its emit step whenever that
// buffer, with the entry in flight and any entry the sink takes, has no room.
// ----------------------------------------------------------------------------
module spf_sieve_divisor_enumerator #(
   parameter int unsigned DIVISOR_SLOTS = spf_pkg::SPF_DIVISOR_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   spf_req_if.sink   req_ch,
   spf_rsp_if.source rsp_ch
);
   import spf_pkg::*;

   // table build status and lookup path
   logic           tbl_done;
   spf_lookup_type lookup;
   factor_type     tbl_rdata;

   // queue between intake and factoring engine
   logic           q_valid;
   spf_item_type   q_item;
   logic           q_pop;

   // factor table: cleared and sieved after reset, read by the engine
   spf_table u_table (
      .clock  (clock),
      .reset  (reset),
      .lookup (lookup),
      .rdata  (tbl_rdata),
      .done   (tbl_done)
   );

   // intake: hold off transactions until the table is built, classify, queue
   spf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .tbl_done (tbl_done),
      .req_ch   (req_ch),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   // engine: factor, expand the divisor list, drain to the response channel
   spf_back #(
      .DIVISOR_SLOTS (DIVISOR_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .lookup    (lookup),
      .tbl_rdata (tbl_rdata),
      .rsp_ch    (rsp_ch)
   );

   // no request transaction before the table is complete
   a_no_accept_during_build: assert property (
      @(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> tbl_done
   ) else $error("request accepted before factor table built");

   // the engine reads the table only once it is complete
   a_lookup_after_build: assert property (
      @(posedge clock) disable iff (reset)
      lookup.en |-> tbl_done
   ) else $error("factor table read during build");

   // dequeue only from a non-empty queue
   a_pop_needs_item: assert property (
      @(posedge clock) disable iff (reset)
      q_pop |-> q_valid
   ) else $error("queue popped while empty");

   // once built, the table stays built
   a_build_done_sticky: assert property (
      @(posedge clock) disable iff (reset)
      tbl_done |=> tbl_done
   ) else $error("table build status dropped");

endmodule

// ----- hw/rtl/spf_table.sv -----
// ----------------------------------------------------------------------------
// spf_table
// Smallest odd prime factor table: clearing pass and sieve after reset,
// then a registered read port for the factoring engine.
// ----------------------------------------------------------------------------
module spf_table (
   input  logic                    clock,
   input  logic                    reset,
   input  spf_pkg::spf_lookup_type lookup,
   output spf_pkg::factor_type     rdata,
   output logic                    done
);
   import spf_pkg::*;

   typedef enum logic [1:0] {
      T_CLEAR,
      T_PRIME,
      T_MARK,
      T_DONE
   } state_type;

   localparam logic [VALUE_W:0] MaxWide  = (VALUE_W+1)'(SPF_MAX_VALUE);
   localparam factor_type       PrimeTop = FACTOR_W'((1 << FACTOR_W) - 1);
   localparam factor_type       PrimeLow = FACTOR_W'(3);

   state_type           state_ff, state_in;
   logic [TABLE_AW-1:0] addr_ff, addr_in;
   factor_type          p_ff, p_in;
   logic [VALUE_W:0]    m_ff, m_in;
   logic                done_ff, done_in;

   factor_type          mem [TABLE_DEPTH];
   factor_type          rd_ff;

   logic                we;
   logic [TABLE_AW-1:0] waddr;
   factor_type          wdata;
   logic [VALUE_W-1:0]  psq;

   assign psq = VALUE_W'(p_ff) * VALUE_W'(p_ff);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      done_in  = done_ff;
      we       = 1'b0;
      waddr    = addr_ff;
      wdata    = '0;
      unique case (state_ff)
         T_CLEAR: begin
            we      = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               p_in     = PrimeTop;
               state_in = T_PRIME;
            end
         end
         T_PRIME: begin
            // walk strides from the top down so the smallest prime writes last
            if (spf_is_odd_prime(p_ff) && ({1'b0, psq} <= MaxWide)) begin
               m_in     = {1'b0, psq};
               state_in = T_MARK;
            end else if (p_ff == PrimeLow) begin
               state_in = T_DONE;
            end else begin
               p_in = p_ff - FACTOR_W'(2);
            end
         end
         T_MARK: begin
            if (m_ff <= MaxWide) begin
               we    = 1'b1;
               waddr = m_ff[VALUE_W-1:1];
               wdata = p_ff;
               m_in  = m_ff + (VALUE_W+1)'({p_ff, 1'b0});
            end else if (p_ff == PrimeLow) begin
               state_in = T_DONE;
            end else begin
               p_in     = p_ff - FACTOR_W'(2);
               state_in = T_PRIME;
            end
         end
         T_DONE: begin
            done_in = 1'b1;
         end
         default: state_in = T_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_CLEAR;
         addr_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         done_ff  <= done_in;
      end
      p_ff <= p_in;
      m_ff <= m_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (lookup.en) begin
         rd_ff <= mem[lookup.addr];
      end
   end

   assign rdata = rd_ff;
   assign done  = done_ff;

endmodule

// ----- hw/rtl/spf_front.sv -----
// ----------------------------------------------------------------------------
// spf_front
// Request intake: accept, classify and queue values for the factoring engine.
// ----------------------------------------------------------------------------
module spf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tbl_done,
   spf_req_if.sink               req_ch,
   output logic                  q_valid,
   output spf_pkg::spf_item_type q_item,
   input  logic                  q_pop
);
   import spf_pkg::*;

   localparam int unsigned QDepth = 2;

   spf_item_type ent_ff [QDepth];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   occ_ff, occ_in;
   logic         accept;
   spf_item_type item;

   function automatic spf_kind_type classify(input value_type v);
      spf_kind_type k;
      if (v < VALUE_W'(2)) begin
         k = KIND_TRIVIAL;
      end else if (v[0]) begin
         k = KIND_ODD;
      end else begin
         k = KIND_EVEN;
      end
      return k;
   endfunction

   assign req_ch.ready = tbl_done && (occ_ff != 2'(QDepth));
   assign accept       = req_ch.valid && req_ch.ready;
   assign item.value   = req_ch.value;
   assign item.kind    = classify(req_ch.value);

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      occ_in  = occ_ff;
      if (accept) begin
         wptr_in = ~wptr_ff;
      end
      if (q_pop) begin
         rptr_in = ~rptr_ff;
      end
      occ_in = occ_ff + 2'(accept) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         occ_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         occ_ff  <= occ_in;
      end
      if (accept) begin
         ent_ff[wptr_ff] <= item;
      end
   end

   assign q_valid = (occ_ff != '0);
   assign q_item  = ent_ff[rptr_ff];

endmodule

// ----- hw/rtl/spf_back.sv -----
// ----------------------------------------------------------------------------
// spf_back
// Factoring engine: prime selection, shared restoring divider, divisor list
// expansion and response drain through a two-entry output buffer.
// ----------------------------------------------------------------------------
module spf_back #(
   parameter int unsigned DIVISOR_SLOTS = spf_pkg::SPF_DIVISOR_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  spf_pkg::spf_item_type   q_item,
   output logic                    q_pop,
   output spf_pkg::spf_lookup_type lookup,
   input  spf_pkg::factor_type     tbl_rdata,
   spf_rsp_if.source               rsp_ch
);
   import spf_pkg::*;

   localparam int unsigned CNT_W  = $clog2(DIVISOR_SLOTS + 1);
   localparam int unsigned IDX_W  = (DIVISOR_SLOTS > 1) ? $clog2(DIVISOR_SLOTS) : 1;
   localparam int unsigned STEP_W = $clog2(VALUE_W);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PICK,
      S_LOOK,
      S_DIV,
      S_CHECK,
      S_MULT,
      S_EMIT
   } state_type;

   typedef struct packed {
      value_type divisor;
      logic      last;
   } out_type;

   state_type          state_ff, state_in;
   value_type          r_ff, r_in;
   value_type          p_ff, p_in;
   value_type          power_ff, power_in;
   logic [CNT_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   value_type          quo_ff, quo_in;
   logic [VALUE_W:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               mpend_ff, mpend_in;
   logic               epend_ff, epend_in;
   logic               elast_ff, elast_in;

   out_type            buf_ff [2];
   logic               bw_ff, bw_in;
   logic               br_ff, br_in;
   logic [1:0]         occ_ff, occ_in;

   value_type          list_mem [DIVISOR_SLOTS];
   value_type          rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   value_type          mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;

   logic [2*VALUE_W-1:0] prod;
   logic [2*VALUE_W-1:0] pow_prod;
   logic [VALUE_W:0]     rem_sh;
   logic                 rem_ge;
   logic                 pop;
   logic                 room;
   logic                 m_issue;
   logic                 e_issue;

   assign prod     = rd_ff * power_ff;
   assign pow_prod = power_ff * p_ff;
   assign rem_sh   = {rem_ff[VALUE_W-1:0], quo_ff[VALUE_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, p_ff});

   assign pop  = (occ_ff != '0) && rsp_ch.ready;
   assign room = ({1'b0, occ_ff} + 3'(epend_ff)) < (3'd2 + 3'(pop));

   assign m_issue = (idx_ff < base_ff) &&
                    (({1'b0, count_ff} + (CNT_W+1)'(mpend_ff)) <
                     (CNT_W+1)'(DIVISOR_SLOTS));
   assign e_issue = (idx_ff < count_ff) && room;

   always_comb begin
      state_in    = state_ff;
      r_in        = r_ff;
      p_in        = p_ff;
      power_in    = power_ff;
      base_in     = base_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      mpend_in    = 1'b0;
      epend_in    = 1'b0;
      elast_in    = elast_ff;
      q_pop       = 1'b0;
      lookup.en   = 1'b0;
      lookup.addr = r_ff[VALUE_W-1:1];
      mem_we      = 1'b0;
      mem_waddr   = count_ff[IDX_W-1:0];
      mem_wdata   = prod[VALUE_W-1:0];
      mem_raddr   = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               r_in      = q_item.value;
               count_in  = CNT_W'(1);
               base_in   = CNT_W'(1);
               power_in  = VALUE_W'(1);
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = VALUE_W'(1);
               case (q_item.kind)
                  KIND_TRIVIAL: begin
                     idx_in   = '0;
                     state_in = S_EMIT;
                  end
                  KIND_EVEN: begin
                     p_in     = VALUE_W'(2);
                     quo_in   = q_item.value;
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = S_DIV;
                  end
                  KIND_ODD: begin
                     lookup.en   = 1'b1;
                     lookup.addr = q_item.value[VALUE_W-1:1];
                     state_in    = S_LOOK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PICK: begin
            // start the next prime, or drain when nothing is left to factor
            if (r_ff <= VALUE_W'(1)) begin
               idx_in   = '0;
               state_in = S_EMIT;
            end else begin
               base_in  = count_ff;
               power_in = VALUE_W'(1);
               if (!r_ff[0]) begin
                  p_in     = VALUE_W'(2);
                  quo_in   = r_ff;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = S_DIV;
               end else begin
                  lookup.en = 1'b1;
                  state_in  = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            // an unmarked entry means the odd part is itself prime
            p_in     = (tbl_rdata == '0) ? r_ff : VALUE_W'(tbl_rdata);
            quo_in   = r_ff;
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = rem_ge ? (rem_sh - {1'b0, p_ff}) : rem_sh;
            quo_in  = {quo_ff[VALUE_W-2:0], rem_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (rem_ff == '0) begin
               r_in     = quo_ff;
               power_in = pow_prod[VALUE_W-1:0];
               idx_in   = '0;
               state_in = S_MULT;
            end else begin
               state_in = S_PICK;
            end
         end
         S_MULT: begin
            // read list[idx], then append list[idx] * power from the registered read
            if (mpend_ff) begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (m_issue) begin
               mpend_in = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end else if (!mpend_ff) begin
               if (r_ff > VALUE_W'(1)) begin
                  quo_in   = r_ff;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = S_DIV;
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_EMIT: begin
            if (e_issue) begin
               epend_in = 1'b1;
               elast_in = ((idx_ff + 1'b1) == count_ff);
               idx_in   = idx_ff + 1'b1;
               if ((idx_ff + 1'b1) == count_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      bw_in  = epend_ff ? ~bw_ff : bw_ff;
      br_in  = pop ? ~br_ff : br_ff;
      occ_in = occ_ff + 2'(epend_ff) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mpend_ff <= 1'b0;
         epend_ff <= 1'b0;
         bw_ff    <= 1'b0;
         br_ff    <= 1'b0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mpend_ff <= mpend_in;
         epend_ff <= epend_in;
         bw_ff    <= bw_in;
         br_ff    <= br_in;
         occ_ff   <= occ_in;
      end
      r_ff     <= r_in;
      p_ff     <= p_in;
      power_ff <= power_in;
      base_ff  <= base_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      elast_ff <= elast_in;
      if (epend_ff) begin
         buf_ff[bw_ff] <= '{divisor: rd_ff, last: elast_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         list_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= list_mem[mem_raddr];
   end

   assign rsp_ch.valid   = (occ_ff != '0);
   assign rsp_ch.divisor = buf_ff[br_ff].divisor;
   assign rsp_ch.last    = buf_ff[br_ff].last;

endmodule
